// ===== sv/sos_pkg.sv =====
`timescale 1ns / 1ps

package sos_pkg;

   // Field widths fixed by the request and result formats.
   localparam int COORD_W  = 16;
   localparam int SHAPE_W  = 4;
   localparam int ACTION_W = 2;
   localparam int EDGE_W   = 5;

   // Default store depth.
   localparam int MAX_VERTICES_DEF = 32;

   // Arithmetic widths derived from the coordinate width.
   localparam int DIFF_W = COORD_W + 1;       // coordinate difference
   localparam int PROD_W = 2 * DIFF_W;        // cross product term
   localparam int NUM_W  = PROD_W + 2;        // cross product after sign fix
   localparam int MULN_W = NUM_W + DIFF_W;    // numerator of interpolation
   localparam int QUO_W  = DIFF_W;            // quotient bits from the divider
   localparam int RES_W  = QUO_W + 2;         // signed rounded quotient

   // Request action codes.
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

   // One stored polygon vertex.
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [SHAPE_W-1:0]        shape;
      logic                      closes;
   } vertex_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic load;
      logic query;
      logic latch_p;
      logic read_q;
      logic calc_geo;
      logic calc_mul;
      logic calc_cmp1;
      logic calc_cmp2;
      logic calc_nmul;
      logic div_start;
      logic commit;
      logic next_edge;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
      logic skip;
      logic hit;
      logic div_done;
      logic commit_ok;
      logic finish_ok;
   } stat_type;

endpackage

// ===== sv/sos_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, rounding to nearest with
// ties away from zero. The caller guarantees |num| < den * 2^QUO_W.
module sos_div
   import sos_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [MULN_W-1:0] num,
   input  logic [NUM_W-1:0]         den,
   output logic                     done,
   output logic signed [RES_W-1:0]  quot
);

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    neg_ff, neg_in;
   logic [NUM_W-1:0]        rem_ff, rem_in;
   logic [QUO_W-1:0]        low_ff, low_in;
   logic [QUO_W-1:0]        q_ff, q_in;
   logic [NUM_W-1:0]        den_ff, den_in;
   logic signed [RES_W-1:0] res_ff, res_in;

   logic [MULN_W-1:0] mag;
   logic [NUM_W:0]    trial;
   logic [NUM_W:0]    twice_rem;
   logic [QUO_W:0]    qround;

   // Magnitude of the numerator, one trial subtraction and the rounding check.
   always_comb begin
      mag       = num[MULN_W-1] ? MULN_W'(-num) : MULN_W'(num);
      trial     = {rem_ff, low_ff[QUO_W-1]};
      twice_rem = {rem_ff, 1'b0};
      qround    = (QUO_W + 1)'(q_ff) + (QUO_W + 1)'(twice_rem >= (NUM_W + 1)'(den_ff));
   end

   // Sequencing of the iterations.
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      res_in  = res_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = CNT_W'(QUO_W);
         neg_in  = num[MULN_W-1];
         rem_in  = mag[MULN_W-1:QUO_W];
         low_in  = mag[QUO_W-1:0];
         q_in    = '0;
         den_in  = den;
      end else if (busy_ff && cnt_ff != '0) begin
         if (trial >= (NUM_W + 1)'(den_ff)) begin
            rem_in = NUM_W'(trial - (NUM_W + 1)'(den_ff));
            q_in   = {q_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = NUM_W'(trial);
            q_in   = {q_ff[QUO_W-2:0], 1'b0};
         end
         low_in = {low_ff[QUO_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
      end else if (busy_ff) begin
         res_in  = neg_ff ? -RES_W'(qround) : RES_W'(qround);
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      q_ff   <= q_in;
      den_ff <= den_in;
      res_ff <= res_in;
   end

   assign done = done_ff;
   assign quot = res_ff;

endmodule

// ===== sv/sos_ctrl.sv =====
`timescale 1ns / 1ps

// Sequencer for request decode and the edge scan of a query.
module sos_ctrl
   import sos_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [ACTION_W-1:0] req_action,
   output logic                req_stall,
   input  stat_type            stat,
   output cmd_type             cmd
);

   typedef enum logic [14:0] {
      ST_IDLE     = 15'b000000000000001,
      ST_RD_P     = 15'b000000000000010,
      ST_WAIT_P   = 15'b000000000000100,
      ST_DECIDE   = 15'b000000000001000,
      ST_WAIT_Q   = 15'b000000000010000,
      ST_MUL      = 15'b000000000100000,
      ST_CMP1     = 15'b000000001000000,
      ST_CMP2     = 15'b000000010000000,
      ST_TEST     = 15'b000000100000000,
      ST_NMUL     = 15'b000001000000000,
      ST_DIV_GO   = 15'b000010000000000,
      ST_DIV_WAIT = 15'b000100000000000,
      ST_COMMIT   = 15'b001000000000000,
      ST_FINISH   = 15'b010000000000000,
      ST_SPARE    = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_action == ACT_CLEAR) begin
                  cmd.clear = 1'b1;
               end else if (req_action == ACT_LOAD) begin
                  cmd.load = 1'b1;
               end else if (req_action == ACT_QUERY) begin
                  cmd.query = 1'b1;
                  state_in  = ST_RD_P;
               end
            end
         end
         ST_RD_P: begin
            state_in = stat.scan_done ? ST_FINISH : ST_WAIT_P;
         end
         ST_WAIT_P: begin
            cmd.latch_p = 1'b1;
            state_in    = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (stat.skip) begin
               cmd.next_edge = 1'b1;
               state_in      = ST_RD_P;
            end else begin
               cmd.read_q = 1'b1;
               state_in   = ST_WAIT_Q;
            end
         end
         ST_WAIT_Q: begin
            cmd.calc_geo = 1'b1;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            cmd.calc_mul = 1'b1;
            state_in     = ST_CMP1;
         end
         ST_CMP1: begin
            cmd.calc_cmp1 = 1'b1;
            state_in      = ST_CMP2;
         end
         ST_CMP2: begin
            cmd.calc_cmp2 = 1'b1;
            state_in      = ST_TEST;
         end
         ST_TEST: begin
            if (stat.hit) begin
               state_in = ST_NMUL;
            end else begin
               cmd.next_edge = 1'b1;
               state_in      = ST_RD_P;
            end
         end
         ST_NMUL: begin
            cmd.calc_nmul = 1'b1;
            state_in      = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (stat.div_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (stat.commit_ok) begin
               cmd.commit    = 1'b1;
               cmd.next_edge = 1'b1;
               state_in      = ST_RD_P;
            end
         end
         ST_FINISH: begin
            if (stat.finish_ok) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// ===== sv/sos_datapath.sv =====
`timescale 1ns / 1ps

// Vertex store, edge geometry, interpolation and result registers.
module sos_datapath
   import sos_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
)(
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output stat_type                  stat,
   input  logic signed [COORD_W-1:0] req_start_x,
   input  logic signed [COORD_W-1:0] req_start_y,
   input  logic signed [COORD_W-1:0] req_start_z,
   input  logic signed [COORD_W-1:0] req_end_x,
   input  logic signed [COORD_W-1:0] req_end_y,
   input  logic signed [COORD_W-1:0] req_end_z,
   input  logic [SHAPE_W-1:0]        req_shape_id,
   input  logic                      req_closes_shape,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_found,
   output logic signed [COORD_W-1:0] rsp_point_x,
   output logic signed [COORD_W-1:0] rsp_point_y,
   output logic signed [COORD_W-1:0] rsp_point_z,
   output logic [EDGE_W-1:0]         rsp_edge_index,
   output logic                      rsp_last
);

   localparam int IW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);

   // Vertex store and its read register.
   vertex_type mem [MAX_VERTICES];
   vertex_type rd_ff;
   vertex_type p_ff;
   vertex_type wr_data;
   logic [IW-1:0] rd_addr;

   // Fill count and the index after the last closed polygon.
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] first_ff, first_in;

   // Scan position and start of the current polygon.
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] ps_ff, ps_in;
   logic [CW-1:0] i_next;
   logic [IW-1:0] j_idx;

   // Query segment.
   logic signed [COORD_W-1:0] x1_ff, y1_ff, z1_ff;
   logic signed [DIFF_W-1:0]  dx_ff, dy_ff, dz_ff;
   logic [SHAPE_W-1:0]        excl_ff;

   // Edge geometry pipeline.
   logic signed [DIFF_W-1:0] ex_ff, ey_ff, ox_ff, oy_ff;
   logic signed [PROD_W-1:0] m_eydx_ff, m_exdy_ff, m_exoy_ff;
   logic signed [PROD_W-1:0] m_eyox_ff, m_dxoy_ff, m_dyox_ff;
   logic signed [NUM_W-1:0]  d_raw_ff, na_raw_ff, nb_raw_ff;
   logic signed [NUM_W-1:0]  d_ff, na_ff, nb_ff;
   logic signed [MULN_W-1:0] mx_ff, my_ff, mz_ff;

   // Divider results.
   logic                    dvx_done, dvy_done, dvz_done;
   logic signed [RES_W-1:0] qx, qy, qz;
   logic [COORD_W-1:0]      px, py, pz;

   // Held crossing and output register.
   logic                      pend_valid_ff, pend_valid_in;
   logic signed [COORD_W-1:0] pend_x_ff, pend_y_ff, pend_z_ff;
   logic [EDGE_W-1:0]         pend_edge_ff;
   logic                      out_valid_ff, out_valid_in;
   logic                      out_found_ff, out_last_ff;
   logic signed [COORD_W-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic [EDGE_W-1:0]         out_edge_ff;
   logic                      out_free;
   logic                      load_ok;

   // Store write on a load request that fits.
   assign load_ok = cmd.load && (count_ff < CW'(MAX_VERTICES));
   assign wr_data = '{x: req_start_x, y: req_start_y, z: req_start_z,
                      shape: req_shape_id, closes: req_closes_shape};

   // Read address: the edge start during the scan, its partner on request.
   assign i_next  = i_ff + 1'b1;
   assign j_idx   = p_ff.closes ? ps_ff[IW-1:0] : i_next[IW-1:0];
   assign rd_addr = cmd.read_q ? j_idx : i_ff[IW-1:0];

   always_ff @(posedge clock) begin
      if (load_ok) begin
         mem[count_ff[IW-1:0]] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   // Fill count and scan counters.
   always_comb begin
      count_in = count_ff;
      first_in = first_ff;
      i_in     = i_ff;
      ps_in    = ps_ff;
      if (cmd.clear) begin
         count_in = '0;
         first_in = '0;
      end else if (load_ok) begin
         count_in = count_ff + 1'b1;
         if (req_closes_shape) begin
            first_in = count_ff + 1'b1;
         end
      end
      if (cmd.query) begin
         i_in  = '0;
         ps_in = '0;
      end else if (cmd.next_edge) begin
         i_in = i_next;
         if (p_ff.closes) begin
            ps_in = i_next;
         end
      end
   end

   // Output register, with the held crossing ahead of it.
   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      out_valid_in  = out_valid_ff;
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         pend_valid_in = 1'b1;
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
         end
      end
      if (cmd.finish) begin
         pend_valid_in = 1'b0;
         out_valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         first_ff      <= '0;
         i_ff          <= '0;
         ps_ff         <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         first_ff      <= first_in;
         i_ff          <= i_in;
         ps_ff         <= ps_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Query latch and the edge arithmetic, one step per command.
   always_ff @(posedge clock) begin
      if (cmd.query) begin
         x1_ff   <= req_start_x;
         y1_ff   <= req_start_y;
         z1_ff   <= req_start_z;
         dx_ff   <= DIFF_W'(req_end_x) - DIFF_W'(req_start_x);
         dy_ff   <= DIFF_W'(req_end_y) - DIFF_W'(req_start_y);
         dz_ff   <= DIFF_W'(req_end_z) - DIFF_W'(req_start_z);
         excl_ff <= req_shape_id;
      end
      if (cmd.latch_p) begin
         p_ff <= rd_ff;
      end
      if (cmd.calc_geo) begin
         ex_ff <= DIFF_W'(rd_ff.x) - DIFF_W'(p_ff.x);
         ey_ff <= DIFF_W'(rd_ff.y) - DIFF_W'(p_ff.y);
         ox_ff <= DIFF_W'(x1_ff) - DIFF_W'(p_ff.x);
         oy_ff <= DIFF_W'(y1_ff) - DIFF_W'(p_ff.y);
      end
      if (cmd.calc_mul) begin
         m_eydx_ff <= PROD_W'(ey_ff) * PROD_W'(dx_ff);
         m_exdy_ff <= PROD_W'(ex_ff) * PROD_W'(dy_ff);
         m_exoy_ff <= PROD_W'(ex_ff) * PROD_W'(oy_ff);
         m_eyox_ff <= PROD_W'(ey_ff) * PROD_W'(ox_ff);
         m_dxoy_ff <= PROD_W'(dx_ff) * PROD_W'(oy_ff);
         m_dyox_ff <= PROD_W'(dy_ff) * PROD_W'(ox_ff);
      end
      if (cmd.calc_cmp1) begin
         d_raw_ff  <= NUM_W'(m_eydx_ff) - NUM_W'(m_exdy_ff);
         na_raw_ff <= NUM_W'(m_exoy_ff) - NUM_W'(m_eyox_ff);
         nb_raw_ff <= NUM_W'(m_dxoy_ff) - NUM_W'(m_dyox_ff);
      end
      // Make the denominator positive by negating all three terms.
      if (cmd.calc_cmp2) begin
         if (d_raw_ff[NUM_W-1]) begin
            d_ff  <= -d_raw_ff;
            na_ff <= -na_raw_ff;
            nb_ff <= -nb_raw_ff;
         end else begin
            d_ff  <= d_raw_ff;
            na_ff <= na_raw_ff;
            nb_ff <= nb_raw_ff;
         end
      end
      if (cmd.calc_nmul) begin
         mx_ff <= MULN_W'(na_ff) * MULN_W'(dx_ff);
         my_ff <= MULN_W'(na_ff) * MULN_W'(dy_ff);
         mz_ff <= MULN_W'(na_ff) * MULN_W'(dz_ff);
      end
   end

   // One divider per coordinate, run in lockstep.
   sos_div u_div_x (
      .clock (clock), .reset (reset), .start (cmd.div_start),
      .num (mx_ff), .den (NUM_W'(d_ff)), .done (dvx_done), .quot (qx)
   );
   sos_div u_div_y (
      .clock (clock), .reset (reset), .start (cmd.div_start),
      .num (my_ff), .den (NUM_W'(d_ff)), .done (dvy_done), .quot (qy)
   );
   sos_div u_div_z (
      .clock (clock), .reset (reset), .start (cmd.div_start),
      .num (mz_ff), .den (NUM_W'(d_ff)), .done (dvz_done), .quot (qz)
   );

   // Crossing point along the query segment.
   assign px = x1_ff + COORD_W'(qx);
   assign py = y1_ff + COORD_W'(qy);
   assign pz = z1_ff + COORD_W'(qz);

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         pend_x_ff    <= px;
         pend_y_ff    <= py;
         pend_z_ff    <= pz;
         pend_edge_ff <= EDGE_W'(i_ff);
         if (pend_valid_ff) begin
            out_found_ff <= 1'b1;
            out_last_ff  <= 1'b0;
            out_x_ff     <= pend_x_ff;
            out_y_ff     <= pend_y_ff;
            out_z_ff     <= pend_z_ff;
            out_edge_ff  <= pend_edge_ff;
         end
      end
      // The held crossing closes the query, or a not-found result does.
      if (cmd.finish) begin
         out_last_ff <= 1'b1;
         if (pend_valid_ff) begin
            out_found_ff <= 1'b1;
            out_x_ff     <= pend_x_ff;
            out_y_ff     <= pend_y_ff;
            out_z_ff     <= pend_z_ff;
            out_edge_ff  <= pend_edge_ff;
         end else begin
            out_found_ff <= 1'b0;
            out_x_ff     <= '0;
            out_y_ff     <= '0;
            out_z_ff     <= '0;
            out_edge_ff  <= '0;
         end
      end
   end

   // Status for the controller.
   always_comb begin
      stat.scan_done = (i_ff >= first_ff);
      stat.skip      = (p_ff.shape == excl_ff) || (!p_ff.closes && (i_next >= first_ff));
      stat.hit       = (d_ff > 0) && !na_ff[NUM_W-1] && (na_ff <= d_ff)
                       && !nb_ff[NUM_W-1] && (nb_ff <= d_ff);
      stat.div_done  = dvx_done && dvy_done && dvz_done;
      stat.commit_ok = out_free || !pend_valid_ff;
      stat.finish_ok = out_free;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_found      = out_found_ff;
   assign rsp_point_x    = out_x_ff;
   assign rsp_point_y    = out_y_ff;
   assign rsp_point_z    = out_z_ff;
   assign rsp_edge_index = out_edge_ff;
   assign rsp_last       = out_last_ff;

endmodule

// ===== sv/segment_obstruction_scan.sv =====
// Clear and load requests are taken in the idle state; a query walks the closed edges in
// store order. Skipped edges are only read; other edges are read from the store, multiplied
// and compared, and a crossing also runs the lockstep divider pass. Output stalls can hold
// the scan, and further requests are stalled until the query ends. Synchronous active-high
// reset empties the store and clears the output; store contents are undefined until loaded.
`timescale 1ns / 1ps

module segment_obstruction_scan
   import sos_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
)(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [ACTION_W-1:0]       req_action,
   input  logic signed [COORD_W-1:0] req_start_x,
   input  logic signed [COORD_W-1:0] req_start_y,
   input  logic signed [COORD_W-1:0] req_start_z,
   input  logic signed [COORD_W-1:0] req_end_x,
   input  logic signed [COORD_W-1:0] req_end_y,
   input  logic signed [COORD_W-1:0] req_end_z,
   input  logic [SHAPE_W-1:0]        req_shape_id,
   input  logic                      req_closes_shape,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_found,
   output logic signed [COORD_W-1:0] rsp_point_x,
   output logic signed [COORD_W-1:0] rsp_point_y,
   output logic signed [COORD_W-1:0] rsp_point_z,
   output logic [EDGE_W-1:0]         rsp_edge_index,
   output logic                      rsp_last
);

   cmd_type  cmd;
   stat_type stat;

   // Request decode and scan sequencing.
   sos_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Store, arithmetic and result registers.
   sos_datapath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_start_z      (req_start_z),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .req_end_z        (req_end_z),
      .req_shape_id     (req_shape_id),
      .req_closes_shape (req_closes_shape),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_point_x      (rsp_point_x),
      .rsp_point_y      (rsp_point_y),
      .rsp_point_z      (rsp_point_z),
      .rsp_edge_index   (rsp_edge_index),
      .rsp_last         (rsp_last)
   );

endmodule
